@@ design/lso_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the layer stack order manager.
// No dependencies; used by the top level by scoped names.
package lso_pkg;

  // Fixed field widths of the request and result words
  localparam int ID_W  = 8;
  localparam int HT_W  = 9;
  localparam int CNT_W = 9;

  // Height value of a hidden layer
  localparam logic [HT_W-1:0] HT_HIDDEN = '1;

  // Request kinds
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_SET   = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_NO_LAYER  = 2'd3
  } status_t;

endpackage

@@ design/lso_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/layer_stack_order_manager.sv @@
`timescale 1ns / 1ps
// Layer stack order manager: slot pool plus z-order stack held in two RAMs.
// Depends on lso_pkg and lso_ram.
//
// One request word is taken at a time; s_tready is high only while the block
// waits for work, and the result word sits in an output register so the next
// request can be taken while it waits for m_tready. Each slot's in-use bit is
// kept beside its height in the height RAM, so after reset the block first
// clears that RAM, one slot per cycle, with s_tready low. Allocate reads the
// in-use bits one slot per cycle until it finds a free slot or reaches the
// last one. Set height and free read the layer's height and in-use bit, then
// walk the layers between the old and new height through the order RAM one
// entry per cycle (at most 255 layers shifted); they finish without a walk
// when the height does not change or the slot is not allocated, and without
// a RAM read for an id beyond the pool. Read at height reads the order RAM,
// and skips it for an empty height. Slots at or above 256 cannot be named by
// layer_id and are not built. The order RAM needs no clearing: it is only
// read for heights inside the stack.
module layer_stack_order_manager #(
  parameter int LAYER_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] layer_id, [16:8] wanted_height, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] result_layer, [16:8] result_height,
                                 // [25:17] visible_count, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int ADDR_SLOTS = (LAYER_SLOTS < 256) ? LAYER_SLOTS : 256;
  localparam int SLOT_W     = $clog2(ADDR_SLOTS);
  localparam int HTU_W      = lso_pkg::HT_W + 1;
  localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(ADDR_SLOTS - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAN  = 8'b00000010,
    S_EVAL  = 8'b00000100,
    S_SHIFT = 8'b00001000,
    S_PLACE = 8'b00010000,
    S_RDORD = 8'b00100000,
    S_FIN   = 8'b01000000,
    S_CLEAR = 8'b10000000
  } state_t;

  state_t state;

  // request fields
  logic [lso_pkg::ID_W-1:0]        in_id;
  logic signed [lso_pkg::HT_W-1:0] in_want;
  lso_pkg::cmd_t                   in_cmd;

  // held request
  lso_pkg::cmd_t                   cmd;
  logic [lso_pkg::ID_W-1:0]        id;
  logic [lso_pkg::HT_W-1:0]        want;

  // control state
  logic [lso_pkg::CNT_W-1:0]       count;
  logic [SLOT_W-1:0]               scan_idx;
  logic [lso_pkg::HT_W-1:0]        src_cur;
  logic [lso_pkg::CNT_W-1:0]       left;
  logic                            pend;
  logic [lso_pkg::HT_W-1:0]        pend_dst;
  logic                            move_up;
  logic                            hide;
  logic                            ins;
  logic [lso_pkg::HT_W-1:0]        tgt_h;

  // staged and output result
  lso_pkg::status_t                res_status;
  logic [lso_pkg::ID_W-1:0]        res_layer;
  logic [lso_pkg::HT_W-1:0]        res_height;
  lso_pkg::status_t                out_status;
  logic [lso_pkg::ID_W-1:0]        out_layer;
  logic [lso_pkg::HT_W-1:0]        out_height;
  logic [lso_pkg::CNT_W-1:0]       out_count;

  // RAM ports; height RAM word is {in_use, height}
  logic                            ht_we;
  logic [SLOT_W-1:0]               ht_waddr;
  logic [HTU_W-1:0]                ht_wdata;
  logic [SLOT_W-1:0]               ht_raddr;
  logic [HTU_W-1:0]                ht_rdata;
  logic                            ht_used;
  logic                            ord_we;
  logic [SLOT_W-1:0]               ord_waddr;
  logic [SLOT_W-1:0]               ord_wdata;
  logic [SLOT_W-1:0]               ord_raddr;
  logic [SLOT_W-1:0]               ord_rdata;

  // clamp arithmetic
  logic signed [10:0]              old_h;
  logic signed [10:0]              cnt_s;
  logic signed [10:0]              tgt;
  logic signed [10:0]              lim;
  logic signed [10:0]              clamp_h;

  assign in_id    = s_tdata[7:0];
  assign in_want  = $signed(s_tdata[16:8]);
  assign in_cmd   = lso_pkg::cmd_t'(s_tuser);
  assign ht_used  = ht_rdata[lso_pkg::HT_W];

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {6'b0, out_count, out_height, out_layer};
  assign m_tuser  = out_status;

  // Height and order memories
  lso_ram #(.WIDTH(HTU_W), .DEPTH(ADDR_SLOTS)) u_ht_ram (
    .clk   (clk),
    .we    (ht_we),
    .waddr (ht_waddr),
    .wdata (ht_wdata),
    .raddr (ht_raddr),
    .rdata (ht_rdata)
  );

  lso_ram #(.WIDTH(SLOT_W), .DEPTH(ADDR_SLOTS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Clamp the wanted height; free always targets hidden
  always_comb begin
    old_h   = 11'($signed(ht_rdata[lso_pkg::HT_W-1:0]));
    cnt_s   = $signed({2'b00, count});
    tgt     = (cmd == lso_pkg::CMD_FREE) ? -11'sd1 : 11'($signed(want));
    lim     = (old_h >= 0) ? (cnt_s - 11'sd1) : cnt_s;
    clamp_h = (tgt > lim) ? lim : tgt;
    if (clamp_h < -11'sd1) begin
      clamp_h = -11'sd1;
    end
  end

  // Read addresses: take the request fields directly while idle, run ahead while scanning
  always_comb begin
    priority if (state == S_IDLE) begin
      ht_raddr = (in_cmd == lso_pkg::CMD_ALLOC) ? '0 : in_id[SLOT_W-1:0];
    end else if (state == S_SCAN) begin
      ht_raddr = (scan_idx == SCAN_LAST) ? scan_idx : scan_idx + 1'b1;
    end else begin
      ht_raddr = id[SLOT_W-1:0];
    end
    ord_raddr = (state == S_IDLE) ? in_want[SLOT_W-1:0] : src_cur[SLOT_W-1:0];
  end

  // Write ports: clear after reset, scan marks a new slot, a free that moves
  // nothing clears the in-use bit, shift moves one entry, place drops the layer
  always_comb begin
    ht_we     = 1'b0;
    ht_waddr  = id[SLOT_W-1:0];
    ht_wdata  = {1'b1, tgt_h};
    ord_we    = 1'b0;
    ord_waddr = tgt_h[SLOT_W-1:0];
    ord_wdata = id[SLOT_W-1:0];
    priority if (state == S_CLEAR) begin
      ht_we    = 1'b1;
      ht_waddr = scan_idx;
      ht_wdata = '0;
    end else if (state == S_SCAN && !ht_used) begin
      ht_we    = 1'b1;
      ht_waddr = scan_idx;
      ht_wdata = {1'b1, lso_pkg::HT_HIDDEN};
    end else if (state == S_EVAL && ht_used && cmd == lso_pkg::CMD_FREE
                 && old_h == clamp_h) begin
      ht_we    = 1'b1;
      ht_wdata = {1'b0, lso_pkg::HT_HIDDEN};
    end else if (state == S_SHIFT && pend) begin
      ht_we     = 1'b1;
      ht_waddr  = ord_rdata;
      ht_wdata  = {1'b1, pend_dst};
      ord_we    = 1'b1;
      ord_waddr = pend_dst[SLOT_W-1:0];
      ord_wdata = ord_rdata;
    end else if (state == S_PLACE) begin
      ht_we    = 1'b1;
      ht_wdata = {cmd != lso_pkg::CMD_FREE, hide ? lso_pkg::HT_HIDDEN : tgt_h};
      ord_we   = !hide;
    end else begin
      ht_we  = 1'b0;
      ord_we = 1'b0;
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      scan_idx <= '0;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result word once taken, unless a new one is loaded
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        // Clear every slot's in-use bit
        S_CLEAR: begin
          if (scan_idx == SCAN_LAST) begin
            state <= S_IDLE;
          end
          scan_idx <= scan_idx + 1'b1;
        end

        S_IDLE: begin
          if (s_tvalid) begin
            cmd      <= in_cmd;
            id       <= in_id;
            want     <= in_want;
            scan_idx <= '0;
            unique case (in_cmd)
              lso_pkg::CMD_ALLOC: begin
                state <= S_SCAN;
              end
              lso_pkg::CMD_SET, lso_pkg::CMD_FREE: begin
                res_status <= lso_pkg::ST_NOT_ALLOC;
                res_layer  <= in_id;
                res_height <= lso_pkg::HT_HIDDEN;
                state      <= (int'(in_id) < ADDR_SLOTS) ? S_EVAL : S_FIN;
              end
              lso_pkg::CMD_READ: begin
                res_status <= lso_pkg::ST_NO_LAYER;
                res_layer  <= '0;
                res_height <= lso_pkg::HT_HIDDEN;
                if (!in_want[lso_pkg::HT_W-1] && ($unsigned(in_want) < count)) begin
                  state <= S_RDORD;
                end else begin
                  state <= S_FIN;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end

        // Find the lowest free slot
        S_SCAN: begin
          if (!ht_used) begin
            res_status <= lso_pkg::ST_OK;
            res_layer  <= lso_pkg::ID_W'(scan_idx);
            res_height <= lso_pkg::HT_HIDDEN;
            state      <= S_FIN;
          end else if (scan_idx == SCAN_LAST) begin
            res_status <= lso_pkg::ST_NO_SLOT;
            res_layer  <= '0;
            res_height <= lso_pkg::HT_HIDDEN;
            state      <= S_FIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        // Old height and in-use bit are in; plan the shift
        S_EVAL: begin
          tgt_h      <= clamp_h[lso_pkg::HT_W-1:0];
          pend       <= 1'b0;
          hide       <= 1'b0;
          ins        <= 1'b0;
          res_status <= ht_used ? lso_pkg::ST_OK : lso_pkg::ST_NOT_ALLOC;
          res_layer  <= id;
          if (!ht_used) begin
            state <= S_FIN;
          end else if (old_h == clamp_h) begin
            res_height <= (cmd == lso_pkg::CMD_FREE) ? lso_pkg::HT_HIDDEN
                                                     : clamp_h[lso_pkg::HT_W-1:0];
            state <= S_FIN;
          end else begin
            state <= S_SHIFT;
            if (old_h > clamp_h) begin
              if (clamp_h >= 0) begin
                move_up <= 1'b1;
                src_cur <= 9'(old_h - 11'sd1);
                left    <= 9'(old_h - clamp_h);
              end else begin
                move_up <= 1'b0;
                hide    <= 1'b1;
                src_cur <= 9'(old_h + 11'sd1);
                left    <= 9'(cnt_s - 11'sd1 - old_h);
              end
            end else begin
              if (old_h >= 0) begin
                move_up <= 1'b0;
                src_cur <= 9'(old_h + 11'sd1);
                left    <= 9'(clamp_h - old_h);
              end else begin
                move_up <= 1'b1;
                ins     <= 1'b1;
                src_cur <= 9'(cnt_s - 11'sd1);
                left    <= 9'(cnt_s - clamp_h);
              end
            end
          end
        end

        // Move one entry per cycle: read next source, write previous one
        S_SHIFT: begin
          if (left != '0) begin
            pend     <= 1'b1;
            pend_dst <= move_up ? (src_cur + 1'b1) : (src_cur - 1'b1);
            src_cur  <= move_up ? (src_cur - 1'b1) : (src_cur + 1'b1);
            left     <= left - 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_PLACE;
            end
          end
        end

        // Drop the layer at its new height or take it out of the stack
        S_PLACE: begin
          if (hide) begin
            count <= count - 1'b1;
          end else if (ins) begin
            count <= count + 1'b1;
          end
          res_height <= (hide || cmd == lso_pkg::CMD_FREE) ? lso_pkg::HT_HIDDEN : tgt_h;
          state <= S_FIN;
        end

        // Order entry at the asked height is in
        S_RDORD: begin
          res_status <= lso_pkg::ST_OK;
          res_layer  <= lso_pkg::ID_W'(ord_rdata);
          res_height <= want;
          state      <= S_FIN;
        end

        // Hand the result word to the output register once it is free
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_layer  <= res_layer;
            out_height <= res_height;
            out_count  <= count;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Stack never holds more layers than there are slots
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= ADDR_SLOTS)
    else $error("visible count above slot count");

  // Only the place step changes the stack size
  a_count_place: assert property (@(posedge clk) disable iff (rst)
    (state != S_PLACE) |=> $stable(count))
    else $error("visible count changed outside place step");

  // Hiding a layer needs a non-empty stack
  a_hide_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE && hide) |-> (count != '0))
    else $error("hide from an empty stack");

  // A finished shift always goes on to place the layer
  a_shift_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && left == '0 && !pend) |=> (state == S_PLACE))
    else $error("shift did not end in place step");

  // No result word is overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_layer) && $stable(out_count)))
    else $error("pending result word overwritten");

endmodule

@@ dv/lso_stack_checker.sv @@
`timescale 1ns / 1ps
// Checker for the layer stack order manager: watches both stream channels,
// predicts each result word from its own slot pool and z-order copy, compares.
// Depends on lso_pkg.
module lso_stack_checker
  import lso_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] layer_id, [16:8] wanted_height
  input  logic [1:0]  s_tuser,   // [1:0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [7:0] result_layer, [16:8] result_height,
                                 // [25:17] visible_count
  input  logic [1:0]  m_tuser,   // [1:0] status
  output int          error_count,
  output int          outstanding,
  output int          requests_seen,
  output int          results_checked,
  output int          peak_depth
);

  typedef struct packed {
    status_t    status;
    logic [7:0] layer;
    logic [8:0] height;
    logic [8:0] count;
  } stack_reply_t;

  // Only slots that an 8-bit id can name exist
  localparam int NAMED = (SLOTS < 256) ? SLOTS : 256;

  // Predicted pool and stack
  bit in_use [256];
  int ht [256];
  int z_order [256];
  int depth;

  stack_reply_t awaited_replies [$];
  stack_reply_t seen;
  stack_reply_t due;
  int fails;
  int n_req;
  int n_chk;
  int deepest;

  initial begin
    fails = 0;
    n_req = 0;
    n_chk = 0;
    deepest = 0;
  end

  function automatic void place(int h, int s);
    z_order[h] = s;
    ht[s] = h;
  endfunction

  // Clamp the wanted height and shift the layers in between; return new height
  function automatic int relocate(int s, int want);
    int was;
    int top;
    int lim;
    int h;
    int k;
    was = ht[s];
    top = depth - 1;
    lim = (was >= 0) ? top : top + 1;
    h = want;
    if (h > lim) h = lim;
    if (h < -1) h = -1;
    if (was > h) begin
      if (h >= 0) begin
        for (k = was; k > h; k--) place(k, z_order[k-1]);
        place(h, s);
      end else begin
        for (k = was; k < top; k++) place(k, z_order[k+1]);
        depth--;
        ht[s] = -1;
      end
    end else if (was < h) begin
      if (was >= 0) begin
        for (k = was; k < h; k++) place(k, z_order[k+1]);
        place(h, s);
      end else begin
        for (k = top; k >= h; k--) place(k + 1, z_order[k]);
        place(h, s);
        depth++;
      end
    end
    return ht[s];
  endfunction

  // Apply one request to the predicted state and build its result word
  function automatic stack_reply_t serve_request(cmd_t cmd, logic [7:0] id, logic [8:0] wh);
    stack_reply_t r;
    int want;
    int s;
    bit known;
    want = $signed(wh);
    known = (int'(id) < NAMED) && in_use[id];
    r.status = ST_OK;
    r.layer = id;
    r.height = HT_HIDDEN;
    case (cmd)
      CMD_ALLOC: begin
        r.status = ST_NO_SLOT;
        r.layer = '0;
        for (s = 0; s < NAMED; s++) begin
          if (!in_use[s]) begin
            in_use[s] = 1'b1;
            ht[s] = -1;
            r.status = ST_OK;
            r.layer = 8'(s);
            break;
          end
        end
      end
      CMD_SET: begin
        if (!known) r.status = ST_NOT_ALLOC;
        else r.height = 9'(relocate(id, want));
      end
      CMD_FREE: begin
        if (!known) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          if (ht[id] >= 0) void'(relocate(id, -1));
          in_use[id] = 1'b0;
        end
      end
      default: begin
        if (want >= 0 && want < depth) begin
          r.layer = 8'(z_order[want]);
          r.height = wh;
        end else begin
          r.status = ST_NO_LAYER;
          r.layer = '0;
        end
      end
    endcase
    r.count = 9'(depth);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 256; i++) in_use[i] = 1'b0;
      depth = 0;
      awaited_replies.delete();
    end else begin
      // Compare an accepted result word with the oldest prediction
      if (m_tvalid && m_tready) begin
        seen.status = status_t'(m_tuser);
        seen.layer = m_tdata[7:0];
        seen.height = m_tdata[16:8];
        seen.count = m_tdata[25:17];
        n_chk++;
        if (awaited_replies.size() == 0) begin
          $error("result word with no request outstanding");
          fails++;
        end else begin
          due = awaited_replies.pop_front();
          if (seen.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, m_tuser);
            fails++;
          end
          if (seen.layer !== due.layer) begin
            $error("result_layer: expected %0d, got %0d", due.layer, seen.layer);
            fails++;
          end
          if (seen.height !== due.height) begin
            $error("result_height: expected %0d, got %0d",
                   $signed(due.height), $signed(seen.height));
            fails++;
          end
          if (seen.count !== due.count) begin
            $error("visible_count: expected %0d, got %0d", due.count, seen.count);
            fails++;
          end
          if (m_tdata[31:26] !== '0) begin
            $error("tdata padding: expected 0, got %0h", m_tdata[31:26]);
            fails++;
          end
        end
      end
      // Predict the result of an accepted request word
      if (s_tvalid && s_tready) begin
        awaited_replies.push_back(serve_request(cmd_t'(s_tuser), s_tdata[7:0],
                                                s_tdata[16:8]));
        n_req++;
        if (depth > deepest) deepest = depth;
      end
    end
    error_count <= fails;
    outstanding <= awaited_replies.size();
    requests_seen <= n_req;
    results_checked <= n_chk;
    peak_depth <= deepest;
  end

endmodule

@@ dv/tb_layer_stack_order_manager.sv @@
`timescale 1ns / 1ps
// Testbench top for the layer stack order manager: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on lso_pkg and lso_stack_checker.
module tb_layer_stack_order_manager;
  import lso_pkg::*;

  localparam int RUN_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_ALLOC;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  int error_count;
  int outstanding;
  int requests_seen;
  int results_checked;
  int peak_depth;

  // Slots granted so far, kept only to aim requests at live layers
  bit granted [256];
  int granted_total = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int stall_left = 0;
  int unsigned stall_draw;
  int cycle_count = 0;

  always #4 clk = ~clk;

  layer_stack_order_manager u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  lso_stack_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .error_count     (error_count),
    .outstanding     (outstanding),
    .requests_seen   (requests_seen),
    .results_checked (results_checked),
    .peak_depth      (peak_depth)
  );

  // Stall the result channel a random number of cycles per word
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tready && m_tvalid) begin
      if ($urandom_range(0, 39) == 0) sink_idle = !sink_idle;
      stall_draw = sink_idle ? $urandom_range(0, 11) : 0;
      if (stall_draw != 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_draw;
      end
    end else if (!m_tready) begin
      if (stall_left <= 1) m_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Timeout after %0d cycles", RUN_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one request word after a random gap; track slot grants
  task automatic issue(input cmd_t cmd, input logic [7:0] id, input logic [8:0] wh);
    int unsigned gap;
    int k;
    if ($urandom_range(0, 39) == 0) src_idle = !src_idle;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, wh, id};
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_ALLOC) begin
      for (k = 0; k < 256; k++) begin
        if (!granted[k]) begin
          granted[k] = 1'b1;
          granted_total++;
          break;
        end
      end
    end else if (cmd == CMD_FREE && granted[id]) begin
      granted[id] = 1'b0;
      granted_total--;
    end
  endtask

  // Mostly a live slot, sometimes any id
  function automatic logic [7:0] pick_id(int unsigned pct_live);
    int unsigned start;
    int k;
    if (granted_total != 0 && $urandom_range(0, 99) < pct_live) begin
      start = $urandom_range(0, 255);
      for (k = 0; k < 256; k++)
        if (granted[(start + k) % 256]) return 8'((start + k) % 256);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Heights near the live stack, plus hide, below hide, top and noise
  function automatic logic [8:0] pick_height(int cap);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return HT_HIDDEN;
      1: return 9'($urandom_range(256, 510));
      2: return 9'd255;
      3: return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(0, (cap + 1 > 255) ? 255 : cap + 1));
    endcase
  endfunction

  // Mixed traffic on a pool held to about cap layers
  task automatic churn(input int cap, input int count);
    int i;
    int unsigned r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        if (granted_total < cap) issue(CMD_ALLOC, 8'($urandom), 9'($urandom));
        else issue(CMD_FREE, pick_id(100), 9'($urandom));
      end else if (r < 62) begin
        issue(CMD_SET, pick_id(88), pick_height(cap));
      end else if (r < 74) begin
        issue(CMD_FREE, pick_id(85), 9'($urandom));
      end else begin
        issue(CMD_READ, 8'($urandom), pick_height(cap));
      end
    end
  endtask

  // Fill the pool, show every layer, shuffle the full stack, then drain it
  task automatic fill_and_drain();
    int k;
    int unsigned off;
    while (granted_total < 256) issue(CMD_ALLOC, 8'($urandom), 9'($urandom));
    issue(CMD_ALLOC, 8'($urandom), 9'($urandom));
    for (k = 0; k < 256; k++) issue(CMD_SET, 8'(k), 9'($urandom_range(0, 255)));
    issue(CMD_READ, 8'($urandom), 9'd255);
    issue(CMD_READ, 8'($urandom), 9'd0);
    repeat (40) issue(CMD_SET, 8'($urandom), pick_height(255));
    repeat (30) issue(CMD_READ, 8'($urandom), pick_height(255));
    off = $urandom_range(0, 255);
    for (k = 0; k < 256; k++) issue(CMD_FREE, 8'((k * 37 + off) % 256), 9'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stack, unallocated slots, clamping, moves, hide, free
    issue(CMD_READ, 8'd0, 9'd0);
    issue(CMD_READ, 8'hFF, HT_HIDDEN);
    issue(CMD_SET, 8'hFF, 9'd0);
    issue(CMD_FREE, 8'd0, 9'd0);
    repeat (4) issue(CMD_ALLOC, 8'd0, 9'd0);
    issue(CMD_SET, 8'd0, 9'd255);
    issue(CMD_SET, 8'd1, 9'd0);
    issue(CMD_SET, 8'd2, 9'd255);
    issue(CMD_SET, 8'd3, 9'h100);
    issue(CMD_SET, 8'd2, 9'd255);
    issue(CMD_SET, 8'd2, 9'd0);
    issue(CMD_SET, 8'd1, 9'd2);
    issue(CMD_SET, 8'd1, HT_HIDDEN);
    issue(CMD_READ, 8'd0, 9'd0);
    issue(CMD_READ, 8'd0, 9'd1);
    issue(CMD_READ, 8'd0, 9'd2);
    issue(CMD_READ, 8'd0, 9'd255);
    issue(CMD_FREE, 8'd2, 9'd0);
    issue(CMD_FREE, 8'd3, 9'd0);
    issue(CMD_ALLOC, 8'hFF, HT_HIDDEN);
    issue(CMD_SET, 8'd4, 9'd1);

    // Random traffic over several pool sizes, one full pool pass
    churn(3, 150);
    churn(16, 250);
    churn(48, 200);
    fill_and_drain();
    churn(8, 200);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result words for %0d requests across all four request kinds.",
             results_checked, requests_seen);
    $display("Deepest stack held %0d layers; the slot pool was exhausted and emptied.",
             peak_depth);
    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
